// ===== design/iad_pkg.sv =====
// Shared types, constants and ADPCM step functions for the IMA ADPCM byte decoder.
`timescale 1ns / 1ps

package iad_pkg;

  localparam int unsigned INDEX_MAX   = 88;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENHANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_L  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_R  = 3'd4;

  localparam logic [31:0] POS_LIMIT = 32'h0000_7FFF;
  localparam logic [31:0] NEG_LIMIT = 32'hFFFF_8000;

  typedef struct packed {
    logic        stereo_mode;
    logic        clip_enable;
    logic        enhance_enable;
    logic [15:0] init_left;
    logic [15:0] init_right;
  } cfg_t;

  // One queued byte, split into its two codes.
  typedef struct packed {
    logic [3:0] code_hi;
    logic [3:0] code_lo;
    logic       restart;
    logic       last;
  } qitem_t;

  typedef struct packed {
    logic [6:0]  idx;
    logic [31:0] pred;
  } chan_t;

  function automatic logic [15:0] step_size(input logic [6:0] i);
    logic [15:0] s;
    case (i)
      7'd0:  s = 16'd7;     7'd1:  s = 16'd8;     7'd2:  s = 16'd9;
      7'd3:  s = 16'd10;    7'd4:  s = 16'd11;    7'd5:  s = 16'd12;
      7'd6:  s = 16'd13;    7'd7:  s = 16'd14;    7'd8:  s = 16'd16;
      7'd9:  s = 16'd17;    7'd10: s = 16'd19;    7'd11: s = 16'd21;
      7'd12: s = 16'd23;    7'd13: s = 16'd25;    7'd14: s = 16'd28;
      7'd15: s = 16'd31;    7'd16: s = 16'd34;    7'd17: s = 16'd37;
      7'd18: s = 16'd41;    7'd19: s = 16'd45;    7'd20: s = 16'd50;
      7'd21: s = 16'd55;    7'd22: s = 16'd60;    7'd23: s = 16'd66;
      7'd24: s = 16'd73;    7'd25: s = 16'd80;    7'd26: s = 16'd88;
      7'd27: s = 16'd97;    7'd28: s = 16'd107;   7'd29: s = 16'd118;
      7'd30: s = 16'd130;   7'd31: s = 16'd143;   7'd32: s = 16'd157;
      7'd33: s = 16'd173;   7'd34: s = 16'd190;   7'd35: s = 16'd209;
      7'd36: s = 16'd230;   7'd37: s = 16'd253;   7'd38: s = 16'd279;
      7'd39: s = 16'd307;   7'd40: s = 16'd337;   7'd41: s = 16'd371;
      7'd42: s = 16'd408;   7'd43: s = 16'd449;   7'd44: s = 16'd494;
      7'd45: s = 16'd544;   7'd46: s = 16'd598;   7'd47: s = 16'd658;
      7'd48: s = 16'd724;   7'd49: s = 16'd796;   7'd50: s = 16'd876;
      7'd51: s = 16'd963;   7'd52: s = 16'd1060;  7'd53: s = 16'd1166;
      7'd54: s = 16'd1282;  7'd55: s = 16'd1411;  7'd56: s = 16'd1552;
      7'd57: s = 16'd1707;  7'd58: s = 16'd1878;  7'd59: s = 16'd2066;
      7'd60: s = 16'd2272;  7'd61: s = 16'd2499;  7'd62: s = 16'd2749;
      7'd63: s = 16'd3024;  7'd64: s = 16'd3327;  7'd65: s = 16'd3660;
      7'd66: s = 16'd4026;  7'd67: s = 16'd4428;  7'd68: s = 16'd4871;
      7'd69: s = 16'd5358;  7'd70: s = 16'd5894;  7'd71: s = 16'd6484;
      7'd72: s = 16'd7132;  7'd73: s = 16'd7845;  7'd74: s = 16'd8630;
      7'd75: s = 16'd9493;  7'd76: s = 16'd10442; 7'd77: s = 16'd11487;
      7'd78: s = 16'd12635; 7'd79: s = 16'd13899; 7'd80: s = 16'd15289;
      7'd81: s = 16'd16818; 7'd82: s = 16'd18500; 7'd83: s = 16'd20350;
      7'd84: s = 16'd22385; 7'd85: s = 16'd24623; 7'd86: s = 16'd27086;
      7'd87: s = 16'd29794;
      default: s = 16'd32767;   // index 88, and anything above clamps to it
    endcase
    return s;
  endfunction

  // Signed index adjustment for the three magnitude bits of a code.
  function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

  // One ADPCM step with optional saturation and enhancement.
  function automatic chan_t adpcm_step(input chan_t cur, input logic [3:0] code,
                                       input logic clip, input logic enh);
    logic [6:0]         i;
    logic [15:0]        st;
    logic [16:0]        delta;
    logic [31:0]        p;
    logic signed [8:0]  ni;
    chan_t              res;
    i = (cur.idx > 7'(INDEX_MAX)) ? 7'(INDEX_MAX) : cur.idx;
    st = step_size(i);
    delta = {4'd0, st[15:3]};
    if (code[2]) delta = delta + {1'b0, st};
    if (code[1]) delta = delta + {2'd0, st[15:1]};
    if (code[0]) delta = delta + {3'd0, st[15:2]};
    if (code[3]) p = cur.pred - {15'd0, delta};
    else         p = cur.pred + {15'd0, delta};
    ni = $signed({2'b00, i}) + 9'(idx_adjust(code[2:0]));
    if (ni < 0)                          res.idx = 7'd0;
    else if (ni > $signed(9'(INDEX_MAX))) res.idx = 7'(INDEX_MAX);
    else                                 res.idx = ni[6:0];
    if (clip) begin
      if (!p[31]) begin
        if (p > POS_LIMIT) p = POS_LIMIT;
      end else if (p < NEG_LIMIT) begin
        p = NEG_LIMIT;
      end
    end
    if (enh && (p != 32'd0)) begin
      if (!p[31]) p = p - 32'd1;
      else        p = p + 32'd1;
    end
    res.pred = p;
    return res;
  endfunction

endpackage

// ===== design/iad_front.sv =====
// Front end: configuration registers and intake of code bytes into queue items.
`timescale 1ns / 1ps

module iad_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  logic [7:0]                     s_byte,
  input  logic                           s_restart,
  input  logic                           s_last,
  output logic                           push,
  input  logic                           q_full,
  output iad_pkg::qitem_t                push_item,
  output iad_pkg::cfg_t                  cfg
);
  import iad_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_mode    <= 1'b0;
      cfg.clip_enable    <= 1'b1;
      cfg.enhance_enable <= 1'b0;
      cfg.init_left      <= 16'd0;
      cfg.init_right     <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEREO:  cfg.stereo_mode    <= cfg_data[0];
        REG_CLIP:    cfg.clip_enable    <= cfg_data[0];
        REG_ENHANCE: cfg.enhance_enable <= cfg_data[0];
        REG_INIT_L:  cfg.init_left      <= cfg_data;
        REG_INIT_R:  cfg.init_right     <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Split the byte into its two codes; high nibble goes first.
  assign s_ready             = !q_full;
  assign push                = s_valid && !q_full;
  assign push_item.code_hi   = s_byte[7:4];
  assign push_item.code_lo   = s_byte[3:0];
  assign push_item.restart   = s_restart;
  assign push_item.last      = s_last;

endmodule

// ===== design/iad_queue.sv =====
// Short queue of code-byte items between the front and back ends.
`timescale 1ns / 1ps

module iad_queue #(
  parameter int unsigned QUEUE_DEPTH = iad_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iad_pkg::qitem_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output iad_pkg::qitem_t head
);
  import iad_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/iad_back.sv =====
// Back end: channel state, two ADPCM steps per byte, and the output register.
`timescale 1ns / 1ps

module iad_back (
  input  logic            clk,
  input  logic            rst,
  input  iad_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  iad_pkg::qitem_t head,
  output logic            pop,
  output logic            m_valid,
  input  logic            m_ready,
  output logic [15:0]     m_first,
  output logic [15:0]     m_second,
  output logic            m_last
);
  import iad_pkg::*;

  chan_t left;
  chan_t right;
  chan_t left_base;
  chan_t right_base;
  chan_t step_hi;
  chan_t step_lo;
  chan_t left_next;
  chan_t right_next;

  // Take the head item whenever the output register is free or draining.
  assign pop = !q_empty && (!m_valid || m_ready);

  always_comb begin
    if (head.restart) begin
      left_base.idx   = 7'd0;
      left_base.pred  = {{16{cfg.init_left[15]}}, cfg.init_left};
      right_base.idx  = 7'd0;
      right_base.pred = {{16{cfg.init_right[15]}}, cfg.init_right};
    end else begin
      left_base  = left;
      right_base = right;
    end
    step_hi = adpcm_step(left_base, head.code_hi, cfg.clip_enable, cfg.enhance_enable);
    // Mono chains the low code onto the left result; stereo runs it on the right.
    step_lo = adpcm_step(cfg.stereo_mode ? right_base : step_hi, head.code_lo,
                         cfg.clip_enable, cfg.enhance_enable);
    if (cfg.stereo_mode) begin
      left_next  = step_hi;
      right_next = step_lo;
    end else begin
      left_next  = step_lo;
      right_next = right_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left    <= '0;
      right   <= '0;
      m_valid <= 1'b0;
    end else begin
      if (pop) begin
        left    <= left_next;
        right   <= right_next;
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_first  <= step_hi.pred[15:0];
      m_second <= step_lo.pred[15:0];
      m_last   <= head.last;
    end
  end

endmodule

// ===== design/ima_adpcm_byte_decoder.sv =====
// Top level of the IMA ADPCM byte decoder: front end, item queue and back end.
`timescale 1ns / 1ps

// Decodes a stream of IMA ADPCM bytes, one byte per item, high nibble first.
// Each accepted byte yields exactly one output item carrying two 16-bit
// samples; in stereo mode they are the left and right samples, in mono they
// are two consecutive samples of the one channel. A set tuser bit on an input
// item reloads the predictors from the init registers and zeroes both step
// indices before that byte is decoded; tlast passes through unchanged.
// Throughput is one byte per clock while the output is accepted: the back
// end runs both nibble steps of a byte combinationally, and that chain (two
// step-table lookups, adds and clamps in series) sets the clock budget. A byte
// passes the queue, then the output register. The front end keeps taking
// bytes while an output waits, until the queue of QUEUE_DEPTH items fills.
// Write the configuration registers only while no byte is in flight:
// index 0 stereo_mode, 1 clip_enable, 2 enhance_enable, 3 init_left,
// 4 init_right; writes to other indexes are dropped.

module ima_adpcm_byte_decoder #(
  parameter int unsigned QUEUE_DEPTH = iad_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iad_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] code_byte
  input  logic                            s_axis_tuser,   // [0] restart
  input  logic                            s_axis_tlast,   // end_of_chunk
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // [15:0] sample_first,
                                                          // [31:16] sample_second
  output logic                            m_axis_tlast    // last_of_chunk
);
  import iad_pkg::*;

  cfg_t   cfg;
  qitem_t push_item;
  qitem_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  // Accept bytes and hold the configuration registers.
  iad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_byte    (s_axis_tdata),
    .s_restart (s_axis_tuser),
    .s_last    (s_axis_tlast),
    .push      (push),
    .q_full    (q_full),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // Decouple intake from decoding so either side can stall alone.
  iad_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  // Advance the channel state and register the two samples.
  iad_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_first  (m_axis_tdata[15:0]),
    .m_second (m_axis_tdata[31:16]),
    .m_last   (m_axis_tlast)
  );

endmodule
